>>> src/pcr_pkg.sv
// Shared types and constants of the pretrigger capture recorder.
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned CHANNELS   = 8;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned POST_W     = 10;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIP_SPEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_SAMPLES = 1'b1;

  localparam logic [DATA_W-1:0] TRIP_SPEED_RESET   = 16'h8000;
  localparam logic [POST_W-1:0] POST_SAMPLES_RESET = 10'd512;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ARM     = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_READ    = 2'd3
  } pcr_op_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_ARMED     = 2'd1,
    MODE_TRIGGERED = 2'd2,
    MODE_FROZEN    = 2'd3
  } pcr_mode_e;

  typedef struct packed {
    pcr_mode_e            mode;
    logic [SLOT_W-1:0]    write_slot;
    logic [COUNT_W-1:0]   stored_count;
    logic [SLOT_W-1:0]    trigger_slot;
  } pcr_status_t;

endpackage

>>> src/pcr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pcr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pcr_lane.sv
// One channel lane: the ring storage of one channel and its gated read data.
`timescale 1ns / 1ps

module pcr_lane #(
  parameter int unsigned RING_DEPTH = pcr_pkg::RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  logic [pcr_pkg::DATA_W-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr_i,
  input  logic                          rd_ok_i,
  output logic [pcr_pkg::DATA_W-1:0]    data_o
);

  logic [pcr_pkg::DATA_W-1:0] rdata;

  pcr_ram #(
    .WIDTH (pcr_pkg::DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  // Transactions other than an in-range read return zero channels.
  assign data_o = rd_ok_i ? rdata : '0;

endmodule

>>> src/pcr_ctrl.sv
// Recorder control: mode state machine, ring pointers, trigger logic and registers.
`timescale 1ns / 1ps

module pcr_ctrl #(
  parameter int unsigned RING_DEPTH = pcr_pkg::RING_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  pcr_pkg::pcr_op_e                 op_i,
  input  logic [pcr_pkg::DATA_W-1:0]       speed_i,
  input  logic                             cfg_valid_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             we_o,
  output logic [$clog2(RING_DEPTH)-1:0]    waddr_o,
  output pcr_pkg::pcr_status_t             status_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  pcr_pkg::pcr_mode_e mode_q, mode_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] trig_q, trig_d;
  logic pend_q, pend_d;
  logic [pcr_pkg::POST_W-1:0] post_q, post_d;
  logic [pcr_pkg::DATA_W-1:0] trip_q, trip_d;
  logic [pcr_pkg::POST_W-1:0] post_cfg_q, post_cfg_d;

  logic [pcr_pkg::DATA_W:0] speed_mag;
  logic trip_hit;
  logic [pcr_pkg::POST_W-1:0] post_dec;
  logic [31:0] slot_ext, count_ext, trig_ext;
  logic we;

  assign speed_mag = speed_i[pcr_pkg::DATA_W-1]
                   ? (17'h10000 - {1'b0, speed_i}) : {1'b0, speed_i};
  assign trip_hit  = speed_mag > {1'b0, trip_q};
  assign post_dec  = post_q - pcr_pkg::POST_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pcr_pkg::MODE_IDLE;
      slot_q     <= '0;
      count_q    <= '0;
      trig_q     <= '0;
      pend_q     <= 1'b0;
      post_q     <= '0;
      trip_q     <= pcr_pkg::TRIP_SPEED_RESET;
      post_cfg_q <= pcr_pkg::POST_SAMPLES_RESET;
    end else begin
      mode_q     <= mode_d;
      slot_q     <= slot_d;
      count_q    <= count_d;
      trig_q     <= trig_d;
      pend_q     <= pend_d;
      post_q     <= post_d;
      trip_q     <= trip_d;
      post_cfg_q <= post_cfg_d;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    slot_d     = slot_q;
    count_d    = count_q;
    trig_d     = trig_q;
    pend_d     = pend_q;
    post_d     = post_q;
    trip_d     = trip_q;
    post_cfg_d = post_cfg_q;
    we         = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        pcr_pkg::REG_TRIP_SPEED:   trip_d = cfg_data_i;
        pcr_pkg::REG_POST_SAMPLES: post_cfg_d = cfg_data_i[pcr_pkg::POST_W-1:0];
        default: ;
      endcase
    end

    if (accept_i) begin
      case (op_i)
        pcr_pkg::OP_SAMPLE: begin
          if (mode_q == pcr_pkg::MODE_ARMED || mode_q == pcr_pkg::MODE_TRIGGERED) begin
            we = 1'b1;
            slot_d = (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + AW'(1);
            if (count_q != CW'(RING_DEPTH)) begin
              count_d = count_q + CW'(1);
            end
            if (mode_q == pcr_pkg::MODE_ARMED) begin
              if (trip_hit) begin
                pend_d = 1'b1;
              end
              if (trip_hit || pend_q) begin
                trig_d = slot_q;
                post_d = post_cfg_q;
                mode_d = pcr_pkg::MODE_TRIGGERED;
              end
            end else begin
              post_d = post_dec;
              if (post_dec == '0) begin
                mode_d = pcr_pkg::MODE_FROZEN;
              end
            end
          end
        end
        pcr_pkg::OP_ARM: begin
          slot_d  = '0;
          count_d = '0;
          trig_d  = '0;
          pend_d  = 1'b0;
          mode_d  = pcr_pkg::MODE_ARMED;
        end
        pcr_pkg::OP_TRIGGER: begin
          pend_d = 1'b1;
        end
        pcr_pkg::OP_READ: ;
        default: ;
      endcase
    end
  end

  assign slot_ext  = 32'(slot_q);
  assign count_ext = 32'(count_q);
  assign trig_ext  = 32'(trig_q);

  assign we_o    = we;
  assign waddr_o = slot_q;

  assign status_o.mode         = mode_q;
  assign status_o.write_slot   = slot_ext[pcr_pkg::SLOT_W-1:0];
  assign status_o.stored_count = count_ext[pcr_pkg::COUNT_W-1:0];
  assign status_o.trigger_slot = trig_ext[pcr_pkg::SLOT_W-1:0];

endmodule

>>> src/pcr_merge.sv
// Merge stage: read-stage tracking and the output register that joins status and lane data.
`timescale 1ns / 1ps

module pcr_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        rd_hit_i,
  input  logic                        out_stall_i,
  input  pcr_pkg::pcr_status_t        status_i,
  input  logic [pcr_pkg::DATA_W-1:0]  lane_data_i [pcr_pkg::CHANNELS],
  output logic                        accept_o,
  output logic                        in_stall_o,
  output logic                        lane_rd_ok_o,
  output logic                        out_valid_o,
  output pcr_pkg::pcr_status_t        status_o,
  output logic [pcr_pkg::DATA_W-1:0]  data_o [pcr_pkg::CHANNELS]
);

  logic s1_valid_q, s1_valid_d;
  logic s1_rd_ok_q;
  logic out_valid_q, out_valid_d;
  logic out_load;
  logic accept;
  pcr_pkg::pcr_status_t status_q;
  logic [pcr_pkg::DATA_W-1:0] data_q [pcr_pkg::CHANNELS];

  assign out_load = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign accept   = in_valid_i && (!s1_valid_q || out_load);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_ok_q <= rd_hit_i;
    end
    if (out_load) begin
      status_q <= status_i;
      data_q   <= lane_data_i;
    end
  end

  assign accept_o     = accept;
  assign in_stall_o   = s1_valid_q && !out_load;
  assign lane_rd_ok_o = s1_rd_ok_q;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_o       = data_q;

endmodule

>>> src/pretrigger_capture_recorder.sv
// Top level of the pretrigger capture recorder.
`timescale 1ns / 1ps

// The recorder keeps a ring of RING_DEPTH slots, each holding eight 16-bit
// channels in eight lanes that are written side by side.
// Input transactions carry an op code with the eight channels and a read slot.
// A sample is stored only while armed or triggered, arm restarts a capture,
// a trigger transaction sets a pending request and a read returns one slot.
// Every input transaction gives exactly one result transaction with the mode,
// pointers and count after the transaction, plus the read channels or zeros.
// The result passes through the read stage, where the lane memories are read,
// and then the output register, and one input is accepted every cycle while
// the receiver takes results.
// When the receiver stalls, the result holds, one more transaction waits in
// the read stage, and the input channel then stalls.
// Configuration writes are always ready and must arrive only while idle.
// Reset puts the recorder in idle with zero pointers and the register
// defaults; the ring contents are undefined until written.
module pretrigger_capture_recorder #(
  parameter int unsigned RING_DEPTH = pcr_pkg::RING_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pcr_pkg::OP_W-1:0]            op_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   angle_turns_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   speed_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   angle_innovation_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   torque_current_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   flux_current_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   torque_current_ref_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   hall_sector_i,
  input  logic signed [pcr_pkg::DATA_W-1:0]   voltage_cmd_i,
  input  logic [pcr_pkg::SLOT_W-1:0]          read_slot_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          mode_o,
  output logic [pcr_pkg::SLOT_W-1:0]          write_slot_o,
  output logic [pcr_pkg::COUNT_W-1:0]         stored_count_o,
  output logic [pcr_pkg::SLOT_W-1:0]          trigger_slot_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_angle_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_speed_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_innovation_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_torque_current_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_flux_current_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_torque_ref_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_sector_o,
  output logic signed [pcr_pkg::DATA_W-1:0]   rd_voltage_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  pcr_pkg::pcr_op_e           op;
  pcr_pkg::pcr_status_t       ctrl_status;
  pcr_pkg::pcr_status_t       out_status;
  logic                       accept;
  logic                       rd_hit;
  logic                       re;
  logic                       we;
  logic                       lane_rd_ok;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [31:0]                rslot_ext;
  logic [pcr_pkg::DATA_W-1:0] chan      [pcr_pkg::CHANNELS];
  logic [pcr_pkg::DATA_W-1:0] lane_data [pcr_pkg::CHANNELS];
  logic [pcr_pkg::DATA_W-1:0] out_data  [pcr_pkg::CHANNELS];

  assign op = pcr_pkg::pcr_op_e'(op_i);

  assign chan[0] = angle_turns_i;
  assign chan[1] = speed_i;
  assign chan[2] = angle_innovation_i;
  assign chan[3] = torque_current_i;
  assign chan[4] = flux_current_i;
  assign chan[5] = torque_current_ref_i;
  assign chan[6] = hall_sector_i;
  assign chan[7] = voltage_cmd_i;

  assign rslot_ext = 32'(read_slot_i);
  assign raddr     = rslot_ext[AW-1:0];
  assign rd_hit    = (op == pcr_pkg::OP_READ) && (rslot_ext < 32'(RING_DEPTH));
  assign re        = accept && rd_hit;

  pcr_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op),
    .speed_i     (speed_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .we_o        (we),
    .waddr_o     (waddr),
    .status_o    (ctrl_status)
  );

  for (genvar g = 0; g < pcr_pkg::CHANNELS; g++) begin : g_lane
    pcr_lane #(
      .RING_DEPTH (RING_DEPTH)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (chan[g]),
      .re_i    (re),
      .raddr_i (raddr),
      .rd_ok_i (lane_rd_ok),
      .data_o  (lane_data[g])
    );
  end

  pcr_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .rd_hit_i     (rd_hit),
    .out_stall_i  (out_stall_i),
    .status_i     (ctrl_status),
    .lane_data_i  (lane_data),
    .accept_o     (accept),
    .in_stall_o   (in_stall_o),
    .lane_rd_ok_o (lane_rd_ok),
    .out_valid_o  (out_valid_o),
    .status_o     (out_status),
    .data_o       (out_data)
  );

  assign cfg_ready_o = 1'b1;

  assign mode_o         = out_status.mode;
  assign write_slot_o   = out_status.write_slot;
  assign stored_count_o = out_status.stored_count;
  assign trigger_slot_o = out_status.trigger_slot;

  assign rd_angle_o          = out_data[0];
  assign rd_speed_o          = out_data[1];
  assign rd_innovation_o     = out_data[2];
  assign rd_torque_current_o = out_data[3];
  assign rd_flux_current_o   = out_data[4];
  assign rd_torque_ref_o     = out_data[5];
  assign rd_sector_o         = out_data[6];
  assign rd_voltage_o        = out_data[7];

endmodule

>>> src/pcr_checker.sv
// Port-level checker for the pretrigger capture recorder and its bind.
`timescale 1ns / 1ps

module pcr_checker #(
  parameter int unsigned RING_DEPTH = pcr_pkg::RING_DEPTH
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [1:0]                         mode_o,
  input logic [pcr_pkg::SLOT_W-1:0]         write_slot_o,
  input logic [pcr_pkg::COUNT_W-1:0]        stored_count_o,
  input logic [pcr_pkg::SLOT_W-1:0]         trigger_slot_o,
  input logic signed [pcr_pkg::DATA_W-1:0]  rd_angle_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o)
      && $stable(write_slot_o) && $stable(stored_count_o) && $stable(rd_angle_o))
    else $error("stalled result changed");

  // A result that appears on an empty output was preceded by an accepted input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input transaction");

  // Idle is only the reset state, so nothing has been recorded yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == pcr_pkg::MODE_IDLE |->
      stored_count_o == '0 && write_slot_o == '0 && trigger_slot_o == '0)
    else $error("idle result with recorded state");

  // Count and pointers stay inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(stored_count_o) <= 32'(RING_DEPTH)
      && 32'(write_slot_o) < 32'(RING_DEPTH) && 32'(trigger_slot_o) < 32'(RING_DEPTH))
    else $error("count or slot outside the ring");

endmodule

bind pretrigger_capture_recorder pcr_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_pcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .mode_o         (mode_o),
  .write_slot_o   (write_slot_o),
  .stored_count_o (stored_count_o),
  .trigger_slot_o (trigger_slot_o),
  .rd_angle_o     (rd_angle_o)
);

>>> bench/tb_top.sv
// Self-checking testbench of the pretrigger capture recorder, built around a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import pcr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED = 20;

  typedef struct packed {
    pcr_op_e                              op;
    logic [CHANNELS-1:0][DATA_W-1:0]      ch;
    logic [SLOT_W-1:0]                    slot;
  } rec_item_t;

  typedef struct packed {
    pcr_status_t                          status;
    logic [CHANNELS-1:0][DATA_W-1:0]      rd;
  } rec_result_t;

  class capture_scoreboard;
    logic [CHANNELS-1:0][DATA_W-1:0] ring [RING_DEPTH];
    bit                              written [RING_DEPTH];
    int unsigned                     filled [$];
    pcr_mode_e                       mode;
    logic [SLOT_W-1:0]               next_slot;
    logic [SLOT_W-1:0]               trig_slot;
    logic [COUNT_W-1:0]              count;
    logic                            pending;
    logic [POST_W-1:0]               post_left;
    logic [DATA_W-1:0]               trip_speed;
    logic [POST_W-1:0]               post_samples;
    rec_result_t                     awaited [$];
    string                           chan_name [CHANNELS];
    int                              errors;
    int                              n_in;
    int                              n_checked;
    int                              n_triggers;
    int                              n_freezes;
    int                              n_reads;
    int                              n_writes;

    function new();
      mode = MODE_IDLE;
      next_slot = '0;
      trig_slot = '0;
      count = '0;
      pending = 1'b0;
      post_left = '0;
      trip_speed = TRIP_SPEED_RESET;
      post_samples = POST_SAMPLES_RESET;
      chan_name = '{"rd_angle", "rd_speed", "rd_innovation", "rd_torque_current",
                    "rd_flux_current", "rd_torque_ref", "rd_sector", "rd_voltage"};
      errors = 0;
      n_in = 0;
      n_checked = 0;
      n_triggers = 0;
      n_freezes = 0;
      n_reads = 0;
      n_writes = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      if (idx == REG_TRIP_SPEED) begin
        trip_speed = data;
      end else begin
        post_samples = data[POST_W-1:0];
      end
    endfunction

    function void note_input(rec_item_t it);
      rec_result_t want;
      int unsigned mag;
      n_in++;
      want.rd = '0;
      case (it.op)
        OP_SAMPLE: begin
          if (mode == MODE_ARMED || mode == MODE_TRIGGERED) begin
            ring[next_slot] = it.ch;
            if (!written[next_slot]) begin
              written[next_slot] = 1'b1;
              filled.push_back(next_slot);
            end
            next_slot = next_slot + 1'b1;
            if (count < COUNT_W'(RING_DEPTH)) count = count + 1'b1;
            if (mode == MODE_ARMED) begin
              mag = it.ch[1][DATA_W-1] ? 32'h10000 - it.ch[1] : it.ch[1];
              if (mag > trip_speed) pending = 1'b1;
              if (pending) begin
                trig_slot = next_slot - 1'b1;
                post_left = post_samples;
                mode = MODE_TRIGGERED;
                n_triggers++;
              end
            end else begin
              post_left = post_left - 1'b1;
              if (post_left == '0) begin
                mode = MODE_FROZEN;
                n_freezes++;
              end
            end
          end
        end
        OP_ARM: begin
          next_slot = '0;
          count = '0;
          trig_slot = '0;
          pending = 1'b0;
          mode = MODE_ARMED;
        end
        OP_TRIGGER: begin
          pending = 1'b1;
        end
        default: begin
          want.rd = ring[it.slot];
          n_reads++;
        end
      endcase
      want.status.mode = mode;
      want.status.write_slot = next_slot;
      want.status.stored_count = count;
      want.status.trigger_slot = trig_slot;
      awaited.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(rec_result_t got);
      rec_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result transaction with nothing awaited", 32'h0, 32'h0);
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.status.mode !== want.status.mode)
        report_mismatch("mode", got.status.mode, want.status.mode);
      if (got.status.write_slot !== want.status.write_slot)
        report_mismatch("write_slot", got.status.write_slot, want.status.write_slot);
      if (got.status.stored_count !== want.status.stored_count)
        report_mismatch("stored_count", got.status.stored_count, want.status.stored_count);
      if (got.status.trigger_slot !== want.status.trigger_slot)
        report_mismatch("trigger_slot", got.status.trigger_slot, want.status.trigger_slot);
      for (int c = 0; c < CHANNELS; c++)
        if (got.rd[c] !== want.rd[c])
          report_mismatch(chan_name[c], got.rd[c], want.rd[c]);
    endtask

    function int waiting();
      return awaited.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic [OP_W-1:0]                   op_drv = '0;
  logic [CHANNELS-1:0][DATA_W-1:0]   ch_drv = '0;
  logic [SLOT_W-1:0]                 slot_drv = '0;
  logic                              out_stall = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]              cfg_index = '0;
  logic [CFG_DATA_W-1:0]             cfg_data = '0;
  bit                                quiet = 1'b0;
  int unsigned                       stuck_cycles = 0;

  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [1:0]                        mode_o;
  logic [SLOT_W-1:0]                 write_slot_o;
  logic [COUNT_W-1:0]                stored_count_o;
  logic [SLOT_W-1:0]                 trigger_slot_o;
  logic [CHANNELS-1:0][DATA_W-1:0]   rd_o;
  logic                              cfg_ready_o;

  capture_scoreboard sb = new();

  pretrigger_capture_recorder dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .op_i                 (op_drv),
    .angle_turns_i        (ch_drv[0]),
    .speed_i              (ch_drv[1]),
    .angle_innovation_i   (ch_drv[2]),
    .torque_current_i     (ch_drv[3]),
    .flux_current_i       (ch_drv[4]),
    .torque_current_ref_i (ch_drv[5]),
    .hall_sector_i        (ch_drv[6]),
    .voltage_cmd_i        (ch_drv[7]),
    .read_slot_i          (slot_drv),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .mode_o               (mode_o),
    .write_slot_o         (write_slot_o),
    .stored_count_o       (stored_count_o),
    .trigger_slot_o       (trigger_slot_o),
    .rd_angle_o           (rd_o[0]),
    .rd_speed_o           (rd_o[1]),
    .rd_innovation_o      (rd_o[2]),
    .rd_torque_current_o  (rd_o[3]),
    .rd_flux_current_o    (rd_o[4]),
    .rd_torque_ref_o      (rd_o[5]),
    .rd_sector_o          (rd_o[6]),
    .rd_voltage_o         (rd_o[7]),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    rec_result_t got;
    if (rst_n && out_valid_o && !out_stall) begin
      got.status.mode = pcr_mode_e'(mode_o);
      got.status.write_slot = write_slot_o;
      got.status.stored_count = stored_count_o;
      got.status.trigger_slot = trigger_slot_o;
      got.rd = rd_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", stuck_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Speeds are pulled toward the trip threshold so both sides of it are hit.
  function automatic logic [DATA_W-1:0] pick_speed();
    int m;
    if ($urandom_range(2) != 0) return pick_word();
    m = int'(sb.trip_speed) - 1 + int'($urandom_range(2));
    if (m < 0) m = 0;
    if (m > 32768) m = 32768;
    return ($urandom_range(1) != 0) ? DATA_W'(32'h10000 - m) : DATA_W'(m);
  endfunction

  function automatic rec_item_t make_sample();
    rec_item_t it;
    it.op = OP_SAMPLE;
    for (int c = 0; c < CHANNELS; c++) it.ch[c] = pick_word();
    it.ch[1] = pick_speed();
    it.slot = SLOT_W'($urandom);
    return it;
  endfunction

  task automatic input_gap();
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_item(rec_item_t it);
    input_gap();
    in_valid <= 1'b1;
    op_drv <= it.op;
    ch_drv <= it.ch;
    slot_drv <= it.slot;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_fill(pcr_op_e op, logic [DATA_W-1:0] fill, logic [SLOT_W-1:0] slot);
    rec_item_t it;
    it.op = op;
    it.ch = {CHANNELS{fill}};
    it.slot = slot;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.waiting() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] trip, logic [CFG_DATA_W-1:0] post);
    drain();
    write_reg(REG_TRIP_SPEED, trip);
    write_reg(REG_POST_SAMPLES, post);
    cfg_valid <= 1'b0;
  endtask

  // Inactive recorders are mostly re-armed; samples they would ignore are not counted.
  task automatic run_phase(int n, int arm_pct, int trig_pct, int read_pct, int quiet_n);
    int done;
    int unsigned r;
    bit counts;
    rec_item_t it;
    done = 0;
    while (done < n) begin
      quiet = (done < quiet_n);
      r = $urandom_range(99);
      it = make_sample();
      counts = 1'b1;
      if (sb.mode == MODE_IDLE || sb.mode == MODE_FROZEN) begin
        if (r < 60) begin
          it.op = OP_ARM;
        end else if (r < 75 && sb.filled.size() > 0) begin
          it.op = OP_READ;
        end else if (r < 80) begin
          it.op = OP_TRIGGER;
        end else begin
          counts = 1'b0;
        end
      end else if (r < arm_pct) begin
        it.op = OP_ARM;
      end else if (r < arm_pct + trig_pct) begin
        it.op = OP_TRIGGER;
      end else if (r < arm_pct + trig_pct + read_pct && sb.filled.size() > 0) begin
        it.op = OP_READ;
      end
      if (it.op == OP_READ)
        it.slot = SLOT_W'(sb.filled[$urandom_range(sb.filled.size() - 1)]);
      send_item(it);
      if (counts) done++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fill(OP_SAMPLE, 16'h7FFF, 10'h3FF);
    send_fill(OP_TRIGGER, 16'h8000, 10'h000);
    send_fill(OP_ARM, 16'hFFFF, 10'h3FF);
    send_fill(OP_SAMPLE, 16'h7FFF, 10'h000);
    send_fill(OP_SAMPLE, 16'h8000, 10'h3FF);
    send_fill(OP_SAMPLE, 16'h0000, 10'h155);
    send_fill(OP_SAMPLE, 16'hFFFF, 10'h2AA);
    send_fill(OP_SAMPLE, 16'h5555, 10'h000);
    send_fill(OP_SAMPLE, 16'hAAAA, 10'h000);
    for (int s = 0; s < 6; s++) send_fill(OP_READ, 16'h0000, SLOT_W'(s));
    send_fill(OP_TRIGGER, 16'h1234, 10'h000);
    send_fill(OP_SAMPLE, 16'h1234, 10'h000);
    send_fill(OP_SAMPLE, 16'hEDCB, 10'h000);
    send_fill(OP_TRIGGER, 16'h0F0F, 10'h000);
    send_fill(OP_READ, 16'h0000, 10'd6);
    send_fill(OP_ARM, 16'h0000, 10'h000);
    send_fill(OP_READ, 16'h0000, 10'd3);
    send_fill(OP_SAMPLE, 16'h4321, 10'h000);
    send_fill(OP_READ, 16'h0000, 10'd0);

    configure(16'd0, 16'd1);
    run_phase(30, 3, 2, 15, 0);
    configure(16'd32768, 16'd1023);
    run_phase(25, 2, 3, 15, 0);
    configure(CFG_DATA_W'($urandom_range(200, 3000)), CFG_DATA_W'($urandom_range(2, 40)));
    run_phase(40, 2, 2, 15, 0);

    // A zero countdown wraps, so this capture fills and overruns the whole ring.
    configure(16'h7FFF, 16'd0);
    send_fill(OP_ARM, 16'h0000, 10'h000);
    send_fill(OP_TRIGGER, 16'h0000, 10'h000);
    run_phase(1100, 0, 1, 3, 300);

    configure(CFG_DATA_W'($urandom_range(0, 32768)), CFG_DATA_W'($urandom_range(1, 60)));
    run_phase(25, 2, 2, 15, 0);

    in_valid <= 1'b0;
    while (sb.waiting() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.waiting() > 0)
      sb.report_mismatch("expected results never delivered", sb.waiting(), 32'h0);

    $display("Checked %0d results of %0d input transactions with %0d register writes.",
             sb.n_checked, sb.n_in, sb.n_writes);
    $display("Captures triggered %0d times, froze %0d times, and %0d slot reads were made.",
             sb.n_triggers, sb.n_freezes, sb.n_reads);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
